>>> rtl/fpmd_pkg.sv
// Package for the fixed-point multiply/divide unit.
// Holds channel payload types, operation codes and shared helpers; no dependencies.
package fpmd_pkg;

  localparam int DIV_STEPS = 88;
  localparam int NUM_W     = 88;
  localparam int LONG_FRAC = 15;

  typedef enum logic [2:0] {
    FN_MUL32   = 3'd0,
    FN_MUL64   = 3'd1,
    FN_DIV32   = 3'd2,
    FN_DIV64   = 3'd3,
    FN_RECIP32 = 3'd4,
    FN_RECIP64 = 3'd5,
    FN_ABS32   = 3'd6,
    FN_ABS64   = 3'd7
  } func_t;

  localparam logic [1:0] FMT_Q15 = 2'd0;
  localparam logic [1:0] FMT_Q12 = 2'd1;
  localparam logic [1:0] FMT_Q24 = 2'd2;

  typedef enum logic [1:0] {K_MUL32, K_MUL64, K_DIV, K_PASS} kind_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               overflow;
    logic               divide_by_zero;
  } out_t;

  typedef struct packed {
    kind_t            kind;
    logic             neg;
    logic             w64;
    logic             dz;
    logic             ovf;
    logic [4:0]       frac;
    logic [31:0]      x;
    logic [31:0]      y;
    logic [63:0]      md;
    logic [NUM_W-1:0] num;
  } cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic             neg;
    logic             w64;
    logic             dz;
    logic             ovf;
    logic [4:0]       frac;
    logic [63:0]      md;
    logic [63:0]      rem;
    logic [NUM_W-1:0] num;
  } stg_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

>>> rtl/fpmd_front.sv
// Front end: decodes an operation, forms magnitudes, signs and the pre-shifted dividend.
// Depends on fpmd_pkg.
module fpmd_front (
  input  fpmd_pkg::in_t  in_data,
  input  logic [1:0]     fmt,
  output fpmd_pkg::cmd_t cmd
);

  logic [4:0]  f;
  logic [63:0] a32s;
  logic [63:0] b32s;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] ma32;
  logic [63:0] n;
  logic [63:0] d;
  logic [63:0] mn;
  logic [4:0]  s;

  always_comb begin
    case (fmt)
      fpmd_pkg::FMT_Q12: f = 5'd12;
      fpmd_pkg::FMT_Q24: f = 5'd24;
      default:           f = 5'd15;
    endcase
    a32s = fpmd_pkg::sext32(in_data.operand_a[31:0]);
    b32s = fpmd_pkg::sext32(in_data.operand_b[31:0]);
    ma   = fpmd_pkg::mag64(in_data.operand_a);
    mb   = fpmd_pkg::mag64(in_data.operand_b);
    ma32 = fpmd_pkg::mag64(a32s);
    n    = '0;
    d    = '0;
    s    = 5'(fpmd_pkg::LONG_FRAC);
    cmd      = '0;
    cmd.kind = fpmd_pkg::K_DIV;
    cmd.frac = f;
    case (in_data.func)
      fpmd_pkg::FN_MUL32: begin
        cmd.kind = fpmd_pkg::K_MUL32;
        cmd.x    = in_data.operand_a[31:0];
        cmd.y    = in_data.operand_b[31:0];
      end
      fpmd_pkg::FN_MUL64: begin
        cmd.kind = fpmd_pkg::K_MUL64;
        cmd.x    = ma[31:0];
        cmd.y    = mb[31:0];
        cmd.neg  = in_data.operand_a[63] ^ in_data.operand_b[63];
        cmd.ovf  = (|ma[63:32]) | (|mb[63:32]);
      end
      fpmd_pkg::FN_DIV32: begin
        n = a32s;
        d = b32s;
        s = f;
      end
      fpmd_pkg::FN_DIV64: begin
        n       = in_data.operand_a;
        d       = in_data.operand_b;
        cmd.w64 = 1'b1;
      end
      fpmd_pkg::FN_RECIP32: begin
        n = 64'd1 << f;
        d = a32s;
        s = f;
      end
      fpmd_pkg::FN_RECIP64: begin
        n       = 64'd1 << fpmd_pkg::LONG_FRAC;
        d       = in_data.operand_a;
        cmd.w64 = 1'b1;
      end
      fpmd_pkg::FN_ABS32: begin
        cmd.kind = fpmd_pkg::K_PASS;
      end
      default: begin
        cmd.kind = fpmd_pkg::K_PASS;
      end
    endcase
    mn = fpmd_pkg::mag64(n);
    if (cmd.kind == fpmd_pkg::K_DIV) begin
      cmd.neg = n[63] ^ d[63];
      cmd.md  = fpmd_pkg::mag64(d);
      cmd.dz  = (cmd.md == 64'd0);
      cmd.num = {24'd0, mn} << s;
    end else if (cmd.kind == fpmd_pkg::K_PASS) begin
      if (in_data.func == fpmd_pkg::FN_ABS32) begin
        cmd.num = {24'd0, fpmd_pkg::sext32(ma32[31:0])};
      end else begin
        cmd.num = {24'd0, ma};
      end
    end
  end

endmodule

>>> rtl/fpmd_fifo.sv
// Two-entry queue between front and back ends.
// Depends on fpmd_pkg.
module fpmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  fpmd_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output fpmd_pkg::cmd_t rd_data,
  output logic           full,
  output logic           empty
);

  fpmd_pkg::cmd_t mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;

  always_comb begin
    wp_nxt  = wp_r ^ do_wr;
    rp_nxt  = rp_r ^ do_rd;
    cnt_nxt = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

>>> rtl/fpmd_back.sv
// Back end: multiplier stage, multiply finish, bit-per-stage divider, result register.
// Depends on fpmd_pkg.
module fpmd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  fpmd_pkg::cmd_t cmd,
  input  logic           cmd_vld,
  output logic           cmd_take,
  output fpmd_pkg::out_t out_data,
  output logic           out_vld,
  input  logic           out_take
);

  localparam int LAST = fpmd_pkg::DIV_STEPS + 1;

  fpmd_pkg::stg_t       pipe_r [LAST+1];
  logic [LAST:0]        vld_r;
  fpmd_pkg::out_t       out_r, out_nxt;
  logic                 out_vld_r;
  logic                 adv;
  fpmd_pkg::stg_t       s0, s1;
  logic signed [32:0]   mx, my;
  logic signed [65:0]   prod;
  logic [63:0]          sh, p64;
  logic [63:0]          lim, qn;
  logic [fpmd_pkg::NUM_W-1:0] q;

  function automatic fpmd_pkg::stg_t div_step(input fpmd_pkg::stg_t st);
    fpmd_pkg::stg_t r;
    logic [64:0]    t;
    r = st;
    t = {st.rem, st.num[fpmd_pkg::NUM_W-1]};
    if (st.kind == fpmd_pkg::K_DIV) begin
      if (t >= {1'b0, st.md}) begin
        t = t - {1'b0, st.md};
        r.num = {st.num[fpmd_pkg::NUM_W-2:0], 1'b1};
      end else begin
        r.num = {st.num[fpmd_pkg::NUM_W-2:0], 1'b0};
      end
      r.rem = t[63:0];
    end
    return r;
  endfunction

  assign adv      = ~out_vld_r | out_take;
  assign cmd_take = adv;
  assign out_data = out_r;
  assign out_vld  = out_vld_r;

  always_comb begin
    mx = (cmd.kind == fpmd_pkg::K_MUL32) ? $signed({cmd.x[31], cmd.x})
                                         : $signed({1'b0, cmd.x});
    my = (cmd.kind == fpmd_pkg::K_MUL32) ? $signed({cmd.y[31], cmd.y})
                                         : $signed({1'b0, cmd.y});
    prod = mx * my;
    s0.kind = cmd.kind;
    s0.neg  = cmd.neg;
    s0.w64  = cmd.w64;
    s0.dz   = cmd.dz;
    s0.ovf  = cmd.ovf;
    s0.frac = cmd.frac;
    s0.md   = cmd.md;
    s0.num  = cmd.num;
    s0.rem  = (cmd.kind == fpmd_pkg::K_MUL32 || cmd.kind == fpmd_pkg::K_MUL64)
              ? prod[63:0] : 64'd0;
  end

  always_comb begin
    s1  = pipe_r[0];
    sh  = 64'($signed(pipe_r[0].rem) >>> pipe_r[0].frac);
    p64 = pipe_r[0].rem >> fpmd_pkg::LONG_FRAC;
    if (pipe_r[0].kind == fpmd_pkg::K_MUL32) begin
      s1.num = {24'd0, fpmd_pkg::sext32(sh[31:0])};
    end else if (pipe_r[0].kind == fpmd_pkg::K_MUL64) begin
      if (pipe_r[0].ovf) begin
        s1.num = '0;
      end else begin
        s1.num = {24'd0, pipe_r[0].neg ? (64'd0 - p64) : p64};
      end
    end
  end

  always_comb begin
    q   = pipe_r[LAST].num;
    qn  = pipe_r[LAST].neg ? (64'd0 - q[63:0]) : q[63:0];
    if (pipe_r[LAST].w64) begin
      lim = pipe_r[LAST].neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    end else begin
      lim = pipe_r[LAST].neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
    end
    out_nxt.divide_by_zero = 1'b0;
    out_nxt.overflow       = pipe_r[LAST].ovf;
    out_nxt.result         = q[63:0];
    if (pipe_r[LAST].kind == fpmd_pkg::K_DIV) begin
      if (pipe_r[LAST].dz) begin
        out_nxt.divide_by_zero = 1'b1;
        out_nxt.overflow       = 1'b0;
        out_nxt.result         = '0;
      end else begin
        out_nxt.overflow = (|q[fpmd_pkg::NUM_W-1:64]) | (q[63:0] > lim);
        out_nxt.result   = pipe_r[LAST].w64 ? qn : fpmd_pkg::sext32(qn[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[LAST-1:0], cmd_vld};
      out_vld_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0] <= s0;
      pipe_r[1] <= s1;
      out_r     <= out_nxt;
    end
  end

  for (genvar k = 2; k <= LAST; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[k] <= div_step(pipe_r[k-1]);
      end
    end
  end

endmodule

>>> rtl/fixed_point_mul_div_unit_top.sv
// Top level of the fixed-point multiply/divide unit.
// Depends on fpmd_pkg, fpmd_front, fpmd_fifo and fpmd_back.
//
// Channel  | Ports                         | Transfer when
// ---------+-------------------------------+----------------------
// input    | push, full, in_data           | push & !full
// result   | empty, pop, out_data          | pop & !empty
// config   | cfg_we, cfg_wdata             | cfg_we
//
// One item per cycle is accepted while the queue is not full. Each item passes the
// queue, then the multiplier and multiply-finish stages, the 88-stage divider (one
// quotient bit per stage) and the result stage. All stages advance together
// and hold while the result register is full and not popped. Reset clears all
// valid bits and sets the format to Q15.
module fixed_point_mul_div_unit_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  fpmd_pkg::in_t  in_data,
  output logic           empty,
  input  logic           pop,
  output fpmd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_wdata
);

  logic [1:0]     fmt_r;
  fpmd_pkg::cmd_t fr_cmd, q_cmd;
  logic           q_empty, q_take, out_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= fpmd_pkg::FMT_Q15;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  fpmd_front u_front (
    .in_data (in_data),
    .fmt     (fmt_r),
    .cmd     (fr_cmd)
  );

  fpmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (fr_cmd),
    .rd_en   (q_take),
    .rd_data (q_cmd),
    .full    (full),
    .empty   (q_empty)
  );

  fpmd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (q_cmd),
    .cmd_vld  (~q_empty),
    .cmd_take (q_take),
    .out_data (out_data),
    .out_vld  (out_vld),
    .out_take (pop)
  );

  assign empty = ~out_vld;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.divide_by_zero) |-> (out_data.result == 64'd0))
    else $error("divide by zero result not zero");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_data.divide_by_zero && out_data.overflow))
    else $error("overflow and divide by zero both set");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result present right after reset");

endmodule

>>> verif/fixed_point_mul_div_unit_top_tb.sv
// Self-checking testbench for fixed_point_mul_div_unit_top.
// Runs a directed table, then random operations. Checks each result against its table
// entry or a built-in fixed-point predictor. Needs fpmd_pkg and the RTL top level.
module fixed_point_mul_div_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  typedef struct {
    fpmd_pkg::func_t fn;
    logic [63:0]     a;
    logic [63:0]     b;
    bit              typed;
    fpmd_pkg::out_t  want;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  fpmd_pkg::in_t  in_data = '0;
  logic empty;
  logic pop = 1'b0;
  fpmd_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;

  fpmd_pkg::out_t expected_q[$];
  logic [1:0] fmt_model = fpmd_pkg::FMT_Q15;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int stall_cnt = 0;
  vec_t vecs[23];

  fixed_point_mul_div_unit_top u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] abs64_of(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] widen32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] fixed_quotient(input logic [63:0] n, input logic [63:0] d,
                                                 input int unsigned s, input bit w64,
                                                 output logic ovf, output logic dz);
    logic neg;
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0] lim;
    logic [63:0] q;
    neg = n[63] ^ d[63];
    ovf = 1'b0;
    dz = 1'b0;
    if (abs64_of(d) == 64'd0) begin
      dz = 1'b1;
      return 64'd0;
    end
    num = {64'd0, abs64_of(n)} << s;
    quo = num / {64'd0, abs64_of(d)};
    if (w64) lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    else lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
    ovf = (quo[127:64] != 64'd0) || (quo[63:0] > lim);
    q = neg ? (64'd0 - quo[63:0]) : quo[63:0];
    return w64 ? q : widen32(q[31:0]);
  endfunction

  function automatic fpmd_pkg::out_t predict_result(input fpmd_pkg::in_t it,
                                                    input logic [1:0] fmt);
    fpmd_pkg::out_t r;
    int unsigned f;
    logic signed [63:0] sp;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] p;
    logic ovf;
    logic dz;
    f = (fmt == fpmd_pkg::FMT_Q12) ? 12 : (fmt == fpmd_pkg::FMT_Q24) ? 24 : 15;
    ovf = 1'b0;
    dz = 1'b0;
    r = '0;
    case (fpmd_pkg::func_t'(it.func))
      fpmd_pkg::FN_MUL32: begin
        sp = $signed(widen32(it.operand_a[31:0])) * $signed(widen32(it.operand_b[31:0]));
        sp = sp >>> f;
        r.result = widen32(sp[31:0]);
      end
      fpmd_pkg::FN_MUL64: begin
        ma = abs64_of(it.operand_a);
        mb = abs64_of(it.operand_b);
        if (ma[63:32] != 0 || mb[63:32] != 0) begin
          ovf = 1'b1;
        end else begin
          p = (ma * mb) >> fpmd_pkg::LONG_FRAC;
          r.result = (it.operand_a[63] ^ it.operand_b[63]) ? (64'd0 - p) : p;
        end
      end
      fpmd_pkg::FN_DIV32: r.result = fixed_quotient(widen32(it.operand_a[31:0]),
                                                    widen32(it.operand_b[31:0]), f, 1'b0,
                                                    ovf, dz);
      fpmd_pkg::FN_DIV64: r.result = fixed_quotient(it.operand_a, it.operand_b,
                                                    fpmd_pkg::LONG_FRAC, 1'b1, ovf, dz);
      fpmd_pkg::FN_RECIP32: r.result = fixed_quotient(64'd1 << f,
                                                      widen32(it.operand_a[31:0]), f, 1'b0,
                                                      ovf, dz);
      fpmd_pkg::FN_RECIP64: r.result = fixed_quotient(64'd1 << fpmd_pkg::LONG_FRAC,
                                                      it.operand_a, fpmd_pkg::LONG_FRAC,
                                                      1'b1, ovf, dz);
      fpmd_pkg::FN_ABS32: begin
        p = abs64_of(widen32(it.operand_a[31:0]));
        r.result = widen32(p[31:0]);
      end
      default: r.result = abs64_of(it.operand_a);
    endcase
    r.overflow = ovf;
    r.divide_by_zero = dz;
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 6))
      0: v = {$urandom, $urandom};
      1: v = widen32($urandom);
      2: v = {32'd0, $urandom};
      3: v = 64'($urandom_range(0, 65535));
      4: begin
        case ($urandom_range(0, 5))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7fff_ffff_ffff_ffff;
          2: v = 64'hffff_ffff_8000_0000;
          3: v = 64'h0000_0000_7fff_ffff;
          4: v = 64'h0000_0000_ffff_ffff;
          default: v = 64'h0000_0001_0000_0000;
        endcase
      end
      5: v = 64'($urandom_range(0, 2));
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    if ($urandom_range(0, 1)) v = 64'd0 - v;
    return v;
  endfunction

  task automatic send_item(input fpmd_pkg::in_t it, input bit typed,
                           input fpmd_pkg::out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_q.push_back(typed ? want : predict_result(it, fmt_model));
    n_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_format(input logic [1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt_model = v;
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    fpmd_pkg::in_t it;
    for (int i = 0; i < count; i++) begin
      it.func = 3'($urandom_range(0, 7));
      it.operand_a = rand_operand();
      it.operand_b = rand_operand();
      send_item(it, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no expectation waiting: %h", out_data);
        errors++;
      end else begin
        fpmd_pkg::out_t e;
        e = expected_q.pop_front();
        n_checked++;
        if (out_data.result !== e.result) begin
          $error("result: expected %h actual %h", e.result, out_data.result);
          errors++;
        end
        if (out_data.overflow !== e.overflow) begin
          $error("overflow: expected %b actual %b", e.overflow, out_data.overflow);
          errors++;
        end
        if (out_data.divide_by_zero !== e.divide_by_zero) begin
          $error("divide_by_zero: expected %b actual %b", e.divide_by_zero,
                 out_data.divide_by_zero);
          errors++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    fpmd_pkg::in_t it;
    vecs[0]  = '{fpmd_pkg::FN_MUL32, 64'h8000, 64'h8000, 1, '{64'h8000, 1'b0, 1'b0}};
    vecs[1]  = '{fpmd_pkg::FN_MUL32, 64'hffff_ffff_8000_0000, 64'h8000_0000, 0, '0};
    vecs[2]  = '{fpmd_pkg::FN_MUL32, 64'h7fff_ffff, 64'h7fff_ffff, 0, '0};
    vecs[3]  = '{fpmd_pkg::FN_MUL64, 64'h2_0000_0000, 64'd1, 1, '{64'd0, 1'b1, 1'b0}};
    vecs[4]  = '{fpmd_pkg::FN_MUL64, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1,
                 '{64'd0, 1'b1, 1'b0}};
    vecs[5]  = '{fpmd_pkg::FN_MUL64, 64'hffff_ffff_0000_0001, 64'hffff_ffff, 0, '0};
    vecs[6]  = '{fpmd_pkg::FN_MUL64, 64'h8000, 64'hffff_ffff_ffff_8000, 1,
                 '{64'hffff_ffff_ffff_8000, 1'b0, 1'b0}};
    vecs[7]  = '{fpmd_pkg::FN_DIV32, 64'h1234, 64'hffff_ffff_0000_0000, 1,
                 '{64'd0, 1'b0, 1'b1}};
    vecs[8]  = '{fpmd_pkg::FN_DIV32, 64'h8000_0000, 64'hffff_ffff, 0, '0};
    vecs[9]  = '{fpmd_pkg::FN_DIV32, 64'h8000, 64'h8000, 1, '{64'h8000, 1'b0, 1'b0}};
    vecs[10] = '{fpmd_pkg::FN_DIV64, 64'h7fff_ffff_ffff_ffff, 64'd1, 0, '0};
    vecs[11] = '{fpmd_pkg::FN_DIV64, 64'h8000_0000_0000_0000, 64'd0, 1,
                 '{64'd0, 1'b0, 1'b1}};
    vecs[12] = '{fpmd_pkg::FN_DIV64, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 0,
                 '0};
    vecs[13] = '{fpmd_pkg::FN_RECIP32, 64'hffff_ffff_0000_0000, 64'd5, 1,
                 '{64'd0, 1'b0, 1'b1}};
    vecs[14] = '{fpmd_pkg::FN_RECIP32, 64'd1, 64'd0, 0, '0};
    vecs[15] = '{fpmd_pkg::FN_RECIP32, 64'hffff_ffff_ffff_ffff, 64'd0, 0, '0};
    vecs[16] = '{fpmd_pkg::FN_RECIP64, 64'd0, 64'd7, 1, '{64'd0, 1'b0, 1'b1}};
    vecs[17] = '{fpmd_pkg::FN_RECIP64, 64'h8000_0000_0000_0000, 64'd0, 0, '0};
    vecs[18] = '{fpmd_pkg::FN_ABS32, 64'hffff_ffff_8000_0000, 64'd0, 1,
                 '{64'hffff_ffff_8000_0000, 1'b0, 1'b0}};
    vecs[19] = '{fpmd_pkg::FN_ABS32, 64'h1234_5678_ffff_fffe, 64'd0, 1,
                 '{64'd2, 1'b0, 1'b0}};
    vecs[20] = '{fpmd_pkg::FN_ABS64, 64'h8000_0000_0000_0000, 64'd0, 1,
                 '{64'h8000_0000_0000_0000, 1'b0, 1'b0}};
    vecs[21] = '{fpmd_pkg::FN_ABS64, 64'hffff_ffff_ffff_fffb, 64'd0, 1,
                 '{64'd5, 1'b0, 1'b0}};
    vecs[22] = '{fpmd_pkg::FN_MUL32, 64'hdead_beef_0001_0000, 64'h0000_0001_0000_8000, 0,
                 '0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vecs[i]) begin
      it.func = vecs[i].fn;
      it.operand_a = vecs[i].a;
      it.operand_b = vecs[i].b;
      send_item(it, vecs[i].typed, vecs[i].want);
    end
    drain_results();

    write_format(fpmd_pkg::FMT_Q24);
    send_idle_pct = 38;
    recv_idle_pct = 70;
    hold_left = 400;
    run_random(250);
    drain_results();

    write_format(fpmd_pkg::FMT_Q12);
    send_idle_pct = 70;
    recv_idle_pct = 38;
    run_random(250);
    drain_results();

    write_format(2'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(125);
    drain_results();

    write_format(fpmd_pkg::FMT_Q15);
    run_random(125);
    drain_results();

    $display("Covered %0d operations, %0d results checked, across Q15, Q12, Q24 and code 3,",
             n_sent, n_checked);
    $display("with sender and receiver idling, a long receiver hold-off and full drains.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
